// ----- design/csad_pkg.sv -----
// shared types and constants for the cascading sorted-array dictionary
package csad_pkg;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MRG_RD,
    ST_MRG_WAIT,
    ST_MRG_CMP,
    ST_CPY_RD,
    ST_CPY_WAIT,
    ST_CPY_WR,
    ST_LK_LEVEL,
    ST_LK_RD,
    ST_LK_WAIT,
    ST_LK_CMP,
    ST_LK_FINAL_RD,
    ST_LK_FINAL_WAIT,
    ST_LK_FINAL_CMP,
    ST_DONE
  } state_e;

  localparam int unsigned DataW = 32;

endpackage

// ----- design/csad_ram.sv -----
// generic single-port-write ram with a registered read
module csad_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- design/cascading_sorted_array_dictionary.sv -----
// top level of the cascading sorted-array dictionary; one item is worked at a time
// insert: merges the new key with each full level below the target level, then copies
// the merged run into the target level; an insert while full is rejected without a merge
// lookup: binary searches each full level, from 0 up, whose bounds hold the key
// the next item is accepted only after the result item is taken
// reset clears state, item count and flags; level store and bounds are read only once written
module cascading_sorted_array_dictionary #(
  parameter int unsigned LEVEL_COUNT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key_value
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // found, rejected, zero fill
);
  import csad_pkg::*;

  localparam int unsigned Depth = 1 << LEVEL_COUNT;
  localparam int unsigned AW    = LEVEL_COUNT;
  localparam int unsigned LW    = $clog2(LEVEL_COUNT + 1);
  localparam int unsigned CW    = LEVEL_COUNT + 1;

  // level store plus two scratch rams of 2^L words each for the merge runs:
  // the current run sits in one scratch ram, the merged output goes to the other,
  // and a select bit swaps their roles after every level
  logic          st_we, sa_we, sb_we;
  logic [AW-1:0] st_wa, st_ra, sa_wa, sa_ra, sb_wa, sb_ra;
  logic [DataW-1:0] st_wd, st_rd, sa_wd, sa_rd, sb_wd, sb_rd;

  csad_ram #(.Width(DataW), .Depth(Depth)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra), .rdata_o(st_rd));
  csad_ram #(.Width(DataW), .Depth(Depth)) u_run_a (
    .clk_i, .we_i(sa_we), .waddr_i(sa_wa), .wdata_i(sa_wd), .raddr_i(sa_ra), .rdata_o(sa_rd));
  csad_ram #(.Width(DataW), .Depth(Depth)) u_run_b (
    .clk_i, .we_i(sb_we), .waddr_i(sb_wa), .wdata_i(sb_wd), .raddr_i(sb_ra), .rdata_o(sb_rd));

  state_e state_q, state_d;
  logic [LEVEL_COUNT-1:0] count_q, count_d;
  logic [DataW-1:0] key_q, key_d;
  logic [LW-1:0] lvl_q, lvl_d, tgt_q, tgt_d;
  logic [CW-1:0] a_q, a_d, b_q, b_d, n_q, n_d, lo_q, lo_d, hi_q, hi_d;
  logic sel_q, sel_d;              // 0: current run in a, 1: in b
  logic found_q, found_d, rej_q, rej_d;
  logic [DataW-1:0] minv_q [LEVEL_COUNT];
  logic [DataW-1:0] maxv_q [LEVEL_COUNT];
  logic mm_we;
  logic [LW-1:0] mm_idx;
  logic [DataW-1:0] mm_min, mm_max;

  logic [CW-1:0] size_w, mid_w;
  logic [AW-1:0] base_w;
  logic [DataW-1:0] cur_rd;
  logic take_a;

  assign size_w = CW'(1) << lvl_q;
  assign base_w = AW'((CW'(1) << lvl_q) - CW'(1));
  assign mid_w  = lo_q + ((hi_q - lo_q) >> 1);
  assign cur_rd = sel_q ? sb_rd : sa_rd;
  assign take_a = (b_q >= size_w) ||
                  ((a_q < n_q) && ($signed(cur_rd) <= $signed(st_rd)));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_DONE);
  assign m_axis_tdata  = {6'd0, rej_q, found_q};

  // trailing ones of the count gives the target level
  function automatic logic [LW-1:0] trail_ones(input logic [LEVEL_COUNT-1:0] c);
    logic [LW-1:0] r;
    logic stop;
    r = '0;
    stop = 1'b0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (!stop && c[i]) r = LW'(i + 1);
      else stop = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    state_d = state_q; count_d = count_q; key_d = key_q;
    lvl_d = lvl_q; tgt_d = tgt_q; a_d = a_q; b_d = b_q; n_d = n_q;
    lo_d = lo_q; hi_d = hi_q; sel_d = sel_q; found_d = found_q; rej_d = rej_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          key_d = s_axis_tdata; found_d = 1'b0; rej_d = 1'b0; lvl_d = '0;
          if (s_axis_tuser == OP_LOOKUP) begin
            state_d = ST_LK_LEVEL;
          end else if (&count_q) begin
            rej_d = 1'b1; state_d = ST_DONE;
          end else begin
            tgt_d = trail_ones(count_q);
            sel_d = 1'b0; n_d = CW'(1); a_d = '0; b_d = '0;
            state_d = (trail_ones(count_q) == '0) ? ST_CPY_RD : ST_MRG_RD;
          end
        end
      end
      ST_MRG_RD:   state_d = ST_MRG_WAIT;
      ST_MRG_WAIT: state_d = ST_MRG_CMP;
      ST_MRG_CMP: begin
        if (take_a) a_d = a_q + CW'(1); else b_d = b_q + CW'(1);
        if (a_q + b_q + CW'(1) == n_q + size_w) begin
          n_d = n_q + size_w; sel_d = ~sel_q; a_d = '0; b_d = '0;
          lvl_d = lvl_q + LW'(1);
          state_d = (lvl_q + LW'(1) == tgt_q) ? ST_CPY_RD : ST_MRG_RD;
        end else begin
          state_d = ST_MRG_RD;
        end
      end
      ST_CPY_RD:   state_d = ST_CPY_WAIT;
      ST_CPY_WAIT: state_d = ST_CPY_WR;
      ST_CPY_WR: begin
        a_d = a_q + CW'(1);
        if (a_q + CW'(1) == n_q) begin
          count_d = count_q + LEVEL_COUNT'(1); state_d = ST_DONE;
        end else state_d = ST_CPY_RD;
      end
      ST_LK_LEVEL: begin
        if (found_q || lvl_q == LW'(LEVEL_COUNT) ||
            (32'(lvl_q) >= LEVEL_COUNT)) begin
          state_d = ST_DONE;
        end else if (count_q[lvl_q] &&
                     !($signed(key_q) < $signed(minv_q[lvl_q])) &&
                     !($signed(key_q) > $signed(maxv_q[lvl_q]))) begin
          lo_d = '0; hi_d = size_w; state_d = ST_LK_RD;
        end else lvl_d = lvl_q + LW'(1);
      end
      ST_LK_RD: begin
        if (lo_q < hi_q) state_d = ST_LK_WAIT;
        else if (lo_q < size_w) state_d = ST_LK_FINAL_WAIT;
        else begin lvl_d = lvl_q + LW'(1); state_d = ST_LK_LEVEL; end
      end
      ST_LK_WAIT: state_d = ST_LK_CMP;
      ST_LK_CMP: begin
        if ($signed(st_rd) < $signed(key_q)) lo_d = mid_w + CW'(1);
        else hi_d = mid_w;
        state_d = ST_LK_RD;
      end
      ST_LK_FINAL_RD:   state_d = ST_LK_FINAL_WAIT;
      ST_LK_FINAL_WAIT: state_d = ST_LK_FINAL_CMP;
      ST_LK_FINAL_CMP: begin
        if (st_rd == key_q) found_d = 1'b1;
        lvl_d = lvl_q + LW'(1); state_d = ST_LK_LEVEL;
      end
      ST_DONE: if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
    sa_we = 1'b0; sa_wa = '0; sa_wd = key_q; sa_ra = '0;
    sb_we = 1'b0; sb_wa = '0; sb_wd = '0; sb_ra = '0;
    mm_we = 1'b0; mm_idx = tgt_q; mm_min = '0; mm_max = '0;
    case (state_q)
      ST_IDLE: begin
        sa_we = s_axis_tvalid && s_axis_tuser == OP_INSERT;
        sa_wd = s_axis_tdata;
      end
      ST_MRG_RD, ST_MRG_WAIT, ST_MRG_CMP: begin
        st_ra = base_w + AW'(b_q);
        sa_ra = AW'(a_q); sb_ra = AW'(a_q);
        if (state_q == ST_MRG_CMP) begin
          if (sel_q) begin sa_we = 1'b1; sa_wa = AW'(a_q + b_q);
            sa_wd = take_a ? cur_rd : st_rd;
          end else begin sb_we = 1'b1; sb_wa = AW'(a_q + b_q);
            sb_wd = take_a ? cur_rd : st_rd;
          end
        end
      end
      ST_CPY_RD, ST_CPY_WAIT, ST_CPY_WR: begin
        sa_ra = AW'(a_q); sb_ra = AW'(a_q);
        if (state_q == ST_CPY_WR) begin
          st_we = 1'b1;
          st_wa = AW'((CW'(1) << tgt_q) - CW'(1) + a_q);
          st_wd = cur_rd;
          if (a_q == '0) begin mm_we = 1'b1; mm_min = cur_rd; end
          if (a_q + CW'(1) == n_q) begin mm_we = 1'b1; mm_max = cur_rd; end
        end
      end
      ST_LK_RD, ST_LK_WAIT, ST_LK_CMP: st_ra = base_w + AW'(mid_w);
      ST_LK_FINAL_RD, ST_LK_FINAL_WAIT, ST_LK_FINAL_CMP: st_ra = base_w + AW'(lo_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mm_we && state_q == ST_CPY_WR) begin
      if (a_q == '0) minv_q[mm_idx] <= mm_min;
      if (a_q + CW'(1) == n_q) maxv_q[mm_idx] <= mm_max;
    end
    key_q <= key_d; tgt_q <= tgt_d; a_q <= a_d; b_q <= b_d; n_q <= n_d;
    lo_q <= lo_d; hi_q <= hi_d; sel_q <= sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; count_q <= '0; lvl_q <= '0;
      found_q <= 1'b0; rej_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; lvl_q <= lvl_d;
      found_q <= found_d; rej_q <= rej_d;
    end
  end

  a_rej_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && rej_q) |-> (&count_q)) else $error("reject while not full");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(rej_q && found_q)) else $error("found and rejected together");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CPY_WR && state_q != ST_IDLE) |=>
      $stable(count_q) || $past(state_q == ST_CPY_WR))
    else $error("count moved outside copy");
endmodule

// ----- tb/tb_cascading_sorted_array_dictionary.sv -----
// testbench for the cascading sorted-array dictionary: directed table, then random traffic
`timescale 1ns / 1ps

module tb_cascading_sorted_array_dictionary;
  import csad_pkg::*;

  localparam int unsigned LEVELS = 10;
  localparam int unsigned CAPACITY = (1 << LEVELS) - 1;

  typedef struct packed {
    logic found;
    logic rejected;
  } answer_t;

  typedef struct {
    op_e         op;
    logic [31:0] key;
    logic        typed; // expected answer written in the row
    answer_t     ans;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  cascading_sorted_array_dictionary #(.LEVEL_COUNT(LEVELS)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // predictor state: a multiset of stored values suffices, since duplicates are kept
  int          held_values[$];
  answer_t     pending_answers[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          keys_seen[$];
  row_t        directed[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("cascading_sorted_array_dictionary regression: fail");
    $finish;
  end

  function automatic answer_t dictionary_answer(op_e op, logic [31:0] key);
    answer_t a;
    a = '0;
    if (op == OP_INSERT) begin
      if (held_values.size() == CAPACITY) a.rejected = 1'b1;
      else held_values.insert(held_values.size(), $signed(key));
    end else begin
      foreach (held_values[i]) if (held_values[i] == $signed(key)) a.found = 1'b1;
    end
    return a;
  endfunction

  function automatic void add_row(op_e op, logic [31:0] key, logic typed, answer_t ans);
    row_t r;
    r.op    = op;
    r.key   = key;
    r.typed = typed;
    r.ans   = ans;
    directed.insert(directed.size(), r);
  endfunction

  // receiver: random stall, compare against oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result %b", $time, m_axis_tdata[1:0]);
          errors++;
        end else begin
          answer_t e;
          e = pending_answers.pop_front();
          if (m_axis_tdata[0] !== e.found || m_axis_tdata[1] !== e.rejected) begin
            $display("%0t: found/rejected expected %b%b actual %b%b", $time,
                     e.found, e.rejected, m_axis_tdata[0], m_axis_tdata[1]);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // tvalid stays high after an accept until the next item or a drain drops it
  task automatic send_item(op_e op, logic [31:0] key, logic typed, answer_t ans);
    answer_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= key;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = dictionary_answer(op, key);
    if (typed && p !== ans) begin
      $display("%0t: table row expected %b%b predictor %b%b", $time,
               ans.found, ans.rejected, p.found, p.rejected);
      errors++;
    end
    pending_answers.insert(pending_answers.size(), typed ? ans : p);
    if (op == OP_INSERT) keys_seen.insert(keys_seen.size(), $signed(key));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic logic [31:0] pick_key();
    if (keys_seen.size() != 0 && $urandom_range(1))
      return keys_seen[$urandom_range(keys_seen.size() - 1)];
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(40);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return 32'h7fff_ffff - $urandom_range(3);
    endcase
  endfunction

  initial begin
    op_e  op;
    // rows: lookup on empty, extremes, duplicates, then mixed inserts and lookups
    add_row(OP_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 1'b0});
    add_row(OP_LOOKUP, 32'h8000_0000, 1'b1, '{1'b0, 1'b0});
    add_row(OP_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 1'b0});
    add_row(OP_INSERT, 32'h7fff_ffff, 1'b1, '{1'b0, 1'b0});
    add_row(OP_LOOKUP, 32'h8000_0000, 1'b1, '{1'b1, 1'b0});
    add_row(OP_LOOKUP, 32'h7fff_ffff, 1'b1, '{1'b1, 1'b0});
    add_row(OP_LOOKUP, 32'hffff_ffff, 1'b1, '{1'b0, 1'b0});
    add_row(OP_INSERT, 32'hffff_ffff, 1'b0, '0);
    add_row(OP_INSERT, 32'hffff_ffff, 1'b0, '0);
    add_row(OP_INSERT, 32'h0000_0000, 1'b0, '0);
    add_row(OP_INSERT, 32'h5555_5555, 1'b0, '0);
    add_row(OP_INSERT, 32'haaaa_aaaa, 1'b0, '0);
    add_row(OP_LOOKUP, 32'hffff_ffff, 1'b0, '0);
    add_row(OP_LOOKUP, 32'haaaa_aaaa, 1'b0, '0);
    add_row(OP_LOOKUP, 32'h5555_5554, 1'b0, '0);
    add_row(OP_LOOKUP, 32'h0000_0000, 1'b0, '0);

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_item(directed[i].op, directed[i].key, directed[i].typed, directed[i].ans);

    // random phases with different idling mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < 100; n++) begin
        op = $urandom_range(1) ? OP_LOOKUP : OP_INSERT;
        send_item(op, pick_key(), 1'b0, '0);
        if (n == 60) drain(); // hold off until the dictionary has answered everything
      end
    end

    // fill to capacity, then hit the full case with lookups between
    send_idle_pct = 0;
    recv_stall_pct = 14;
    while (held_values.size() < CAPACITY) send_item(OP_INSERT, pick_key(), 1'b0, '0);
    send_item(OP_INSERT, 32'h0000_0001, 1'b1, '{1'b0, 1'b1});
    for (int n = 0; n < 30; n++)
      send_item($urandom_range(1) ? OP_LOOKUP : OP_INSERT, pick_key(), 1'b0, '0);

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("cascading_sorted_array_dictionary regression: pass");
    end else begin
      $display("cascading_sorted_array_dictionary regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/csad_pkg.sv
design/csad_ram.sv
design/cascading_sorted_array_dictionary.sv
tb/tb_cascading_sorted_array_dictionary.sv
